// File: rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, register codes and the rounding divider of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	// register index, decoded from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// tuser codes of an input word
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int CHAN_W = 8;
	localparam int COL_W  = 10; // three pixels of one channel
	localparam int SUM_W  = 12; // nine pixels of one channel
	localparam int CNT_W  = 4;  // neighbor count, up to nine

	// ceil(2^16 / d) for d = 6, 12, 18; exact over every numerator the
	// matching count can produce
	localparam int RCP_SH = 16;
	localparam logic [15:0] RCP_6  = 16'd10923;
	localparam logic [15:0] RCP_12 = 16'd5462;
	localparam logic [15:0] RCP_18 = 16'd3641;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	// floor((2*sum + cnt) / (2*cnt)); cnt only takes the values below
	function automatic logic [CHAN_W-1:0] round_div(input logic [SUM_W-1:0] sum,
			input logic [CNT_W-1:0] cnt);
		logic [SUM_W:0] num;
		logic [SUM_W:0] quo;
		logic [SUM_W+RCP_SH:0] prod;
		num = {sum, 1'b0} + {{(SUM_W-CNT_W+1){1'b0}}, cnt};
		prod = '0;
		case (cnt)
			4'd1:    quo = num >> 1;
			4'd2:    quo = num >> 2;
			4'd3: begin
				prod = num * RCP_6;
				quo  = prod[SUM_W+RCP_SH:RCP_SH];
			end
			4'd4:    quo = num >> 3;
			4'd6: begin
				prod = num * RCP_12;
				quo  = prod[SUM_W+RCP_SH:RCP_SH];
			end
			4'd9: begin
				prod = num * RCP_18;
				quo  = prod[SUM_W+RCP_SH:RCP_SH];
			end
			default: quo = '0;
		endcase
		return quo[CHAN_W-1:0];
	endfunction

endpackage

// File: rtl/core/box_blur_3x3_edge_normalized.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized
// Streaming 3x3 box blur of RGB pixels with edge-normalized rounded means.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each leaves as the rounded mean of the
// neighbors that lie inside the image. Output trails input by one row plus
// one pixel; after the last pixel send image_width+1 flush words (tuser=1) to
// drain. Each word passes two states: IDLE reads the two line memories at the
// current column on accept and CALC sums, divides, writes back and updates the
// counters, so no new word is taken until the last is done. A finished pixel
// waits in the output register while the next word is read. Any register write
// restarts the image and drops a pending output.
module box_blur_3x3_edge_normalized #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // blue_in, green_in, red_in
	input  logic        s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // blue_out, green_out, red_out
	output logic        m_axis_tlast,  // last_of_image
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
	localparam int CW = bb3_pkg::CHAN_W;
	localparam int LW = bb3_pkg::COL_W;
	localparam int SW = bb3_pkg::SUM_W;

	bb3_pkg::state_t state_q;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [LW-1:0] win0_q [3];
	logic [LW-1:0] win1_q [3];
	logic          op_q;
	logic [23:0]   pix_q;

	logic [23:0] upper_mem [MAX_WIDTH];
	logic [23:0] middle_mem [MAX_WIDTH];
	logic [23:0] up_rd_q, mid_rd_q;

	logic [23:0] out_data_q;
	logic        out_valid_q, out_last_q;

	logic cfg_wr;
	logic s_acc;
	logic draining, is_pixel, ignore, emit, last, go;
	logic [LW-1:0] col [3];
	logic [SW-1:0] sum [3];
	logic [23:0]   res;
	logic [1:0]    rows, cols;
	logic [bb3_pkg::CNT_W-1:0] cnt;
	logic [WW:0] in_col_inc, out_col_inc;
	logic [31:0] wclamp, hclamp;

	assign pready        = 1'b1;
	assign cfg_wr        = psel & penable & pwrite & pready;
	assign s_axis_tready = (state_q == bb3_pkg::ST_IDLE);
	assign s_acc         = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		wclamp = {21'd0, pwdata[10:0]};
		if (wclamp == 32'd0) begin
			wclamp = 32'd1;
		end else if (wclamp > 32'(MAX_WIDTH)) begin
			wclamp = 32'(MAX_WIDTH);
		end
		hclamp = {19'd0, pwdata[12:0]};
		if (hclamp == 32'd0) begin
			hclamp = 32'd1;
		end else if (hclamp > 32'(MAX_HEIGHT)) begin
			hclamp = 32'(MAX_HEIGHT);
		end
	end

	always_comb begin
		unique case (paddr[2])
			bb3_pkg::REG_WIDTH:  prdata = 32'(width_q);
			bb3_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default:             prdata = '0;
		endcase
	end

	// sum, count and divide for the word read on accept
	always_comb begin
		draining = ({1'b0, in_row_q} >= {{(RW+1-HW){1'b0}}, height_q});
		is_pixel = !draining;
		ignore   = !draining && (op_q == bb3_pkg::OP_FLUSH);
		emit     = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
		rows = 2'd1 + ((out_row_q != '0) ? 2'd1 : 2'd0)
			+ (((RW+1)'(out_row_q) + 1'b1 < (RW+1)'(height_q)) ? 2'd1 : 2'd0);
		cols = 2'd1 + ((out_col_q != '0) ? 2'd1 : 2'd0)
			+ (((WW+1)'(out_col_q) + 1'b1 < (WW+1)'(width_q)) ? 2'd1 : 2'd0);
		cnt = {2'b00, rows} * {2'b00, cols};
		for (int ch = 0; ch < 3; ch++) begin
			col[ch] = '0;
			if (in_row_q >= RW'(2)) col[ch] += LW'(up_rd_q[ch*CW +: CW]);
			if (in_row_q >= RW'(1)) col[ch] += LW'(mid_rd_q[ch*CW +: CW]);
			if (is_pixel) col[ch] += LW'(pix_q[ch*CW +: CW]);
			sum[ch] = SW'(win1_q[ch]);
			if (out_col_q != '0) sum[ch] += SW'(win0_q[ch]);
			if (in_col_q != '0) sum[ch] += SW'(col[ch]);
			res[ch*CW +: CW] = bb3_pkg::round_div(sum[ch], cnt);
		end
		last = ((RW+1)'(out_row_q) + 1'b1 == (RW+1)'(height_q))
			&& ((WW+1)'(out_col_q) + 1'b1 == (WW+1)'(width_q));
		in_col_inc  = (WW+1)'(in_col_q) + 1'b1;
		out_col_inc = (WW+1)'(out_col_q) + 1'b1;
		// hold while a result would overwrite one not yet taken
		go = (state_q == bb3_pkg::ST_CALC)
			&& (ignore || !emit || !out_valid_q || m_axis_tready);
	end

	// line memories: read on accept, write back when the word completes
	always_ff @(posedge clk) begin
		if (s_acc) begin
			up_rd_q  <= upper_mem[in_col_q];
			mid_rd_q <= middle_mem[in_col_q];
		end
		if (go && !ignore) begin
			upper_mem[in_col_q]  <= mid_rd_q;
			middle_mem[in_col_q] <= is_pixel ? pix_q : 24'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= s_axis_tuser;
			pix_q <= s_axis_tdata;
		end
		if (go && !ignore && emit) begin
			out_data_q <= res;
			out_last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bb3_pkg::ST_IDLE;
			width_q     <= WW'(W_RST);
			height_q    <= HW'(H_RST);
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_valid_q <= 1'b0;
			for (int ch = 0; ch < 3; ch++) begin
				win0_q[ch] <= '0;
				win1_q[ch] <= '0;
			end
		end else begin
			unique case (state_q)
				bb3_pkg::ST_IDLE: begin
					if (s_acc) state_q <= bb3_pkg::ST_CALC;
				end
				bb3_pkg::ST_CALC: begin
					if (go) state_q <= bb3_pkg::ST_IDLE;
				end
				default: state_q <= bb3_pkg::ST_IDLE;
			endcase
			if (cfg_wr) begin
				if (paddr[2] == bb3_pkg::REG_WIDTH) begin
					width_q <= WW'(wclamp);
				end else begin
					height_q <= HW'(hclamp);
				end
				in_col_q    <= '0;
				in_row_q    <= '0;
				out_col_q   <= '0;
				out_row_q   <= '0;
				out_valid_q <= 1'b0;
				for (int ch = 0; ch < 3; ch++) begin
					win0_q[ch] <= '0;
					win1_q[ch] <= '0;
				end
			end else begin
				if (go && !ignore && emit) begin
					out_valid_q <= 1'b1;
				end else if (out_valid_q && m_axis_tready) begin
					out_valid_q <= 1'b0;
				end
				if (go && !ignore) begin
					if (emit && last) begin
						// image done: start the next one from the top
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
						for (int ch = 0; ch < 3; ch++) begin
							win0_q[ch] <= '0;
							win1_q[ch] <= '0;
						end
					end else begin
						for (int ch = 0; ch < 3; ch++) begin
							win0_q[ch] <= win1_q[ch];
							win1_q[ch] <= col[ch];
						end
						if (in_col_inc >= (WW+1)'(width_q)) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + 1'b1;
						end else begin
							in_col_q <= in_col_inc[AW-1:0];
						end
						if (emit) begin
							if (out_col_inc >= (WW+1)'(width_q)) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + 1'b1;
							end else begin
								out_col_q <= out_col_inc[AW-1:0];
							end
						end
					end
				end
			end
		end
	end

endmodule

// File: sim/box_blur_3x3_edge_normalized_tb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_tb
// Self-checking bench for the streaming 3x3 edge-normalized box blur.
// ----------------------------------------------------------------------------
// A directed table covers register saturation, ignored early flushes, pixels
// sent while draining, tiny images and all-white frames. Random images of
// mostly small sizes follow, with one full-width image cut short in its
// second row and now and then a full-height one cut short, under several idle and
// stall patterns. Each output word is compared against the value from the directed
// table or from a behavioral blur model kept inside the bench.
`timescale 1ns / 1ps

module box_blur_3x3_edge_normalized_tb;

	localparam int LINE_DEPTH = 1024;
	localparam int IDLE_LIMIT = 5000;
	localparam int ITEM_TARGET = 1600;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
	} blur_pix_t;

	typedef struct {
		bit        is_cfg;
		logic      cfg_reg;
		int        cfg_val;
		logic      op;
		logic [23:0] pix;     // {red, green, blue}
		bit        typed;
		blur_pix_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // blue_in, green_in, red_in
	logic        s_axis_tuser;  // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // blue_out, green_out, red_out
	logic        m_axis_tlast;  // last_of_image
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	box_blur_3x3_edge_normalized u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// blur model state
	logic [23:0] upper_mem [LINE_DEPTH];
	logic [23:0] middle_mem [LINE_DEPTH];
	int          win_prev [3];
	int          win_last [3];
	int          in_row, in_col, out_row, out_col;
	int          img_width, img_height;

	blur_pix_t   blur_q [$];
	int          errors = 0;
	int          words_in = 0;
	int          words_out = 0;
	int          images_done = 0;
	int          settings_done = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          rx_hold_left = 0;
	int          quiet_cycles = 0;

	function automatic void restart_image();
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
		for (int ch = 0; ch < 3; ch++) begin
			win_prev[ch] = 0;
			win_last[ch] = 0;
		end
	endfunction

	function automatic int clamp_reg(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void set_geometry(logic reg_sel, int value);
		if (reg_sel == bb3_pkg::REG_WIDTH)
			img_width = clamp_reg(value & 'h7FF, 1024);
		else
			img_height = clamp_reg(value & 'h1FFF, 4096);
		restart_image();
	endfunction

	// -1: ignored, 0: no output, 1: output word in res
	function automatic int blur_word(logic op, logic [23:0] pix, output blur_pix_t res);
		int c, s, cnt, rows, cols, q;
		int colsum [3];
		logic [7:0] outv [3];
		bit draining, is_pix, emit;
		res = '0;
		draining = in_row >= img_height;
		if (!draining && op == bb3_pkg::OP_FLUSH)
			return -1;
		is_pix = !draining;
		c = in_col % LINE_DEPTH;
		for (int ch = 0; ch < 3; ch++) begin
			s = 0;
			if (in_row >= 2)
				s += upper_mem[c][8*ch +: 8];
			if (in_row >= 1)
				s += middle_mem[c][8*ch +: 8];
			if (is_pix)
				s += pix[8*ch +: 8];
			colsum[ch] = s;
		end
		upper_mem[c] = middle_mem[c];
		middle_mem[c] = is_pix ? pix : 24'h0;
		emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
		if (emit) begin
			rows = 1 + (out_row >= 1) + (out_row + 1 < img_height);
			cols = 1 + (out_col >= 1) + (out_col + 1 < img_width);
			cnt = rows * cols;
			for (int ch = 0; ch < 3; ch++) begin
				s = win_last[ch];
				if (out_col >= 1)
					s += win_prev[ch];
				if (in_col >= 1)
					s += colsum[ch];
				q = (2 * s + cnt) / (2 * cnt);
				outv[ch] = q[7:0];
			end
			res.blue = outv[0];
			res.green = outv[1];
			res.red = outv[2];
			res.last = out_row + 1 == img_height && out_col + 1 == img_width;
		end
		for (int ch = 0; ch < 3; ch++) begin
			win_prev[ch] = win_last[ch];
			win_last[ch] = colsum[ch];
		end
		in_col++;
		if (in_col >= img_width) begin
			in_col = 0;
			in_row++;
		end
		if (emit) begin
			if (res.last) begin
				restart_image();
			end else begin
				out_col++;
				if (out_col >= img_width) begin
					out_col = 0;
					out_row++;
				end
			end
		end
		return emit ? 1 : 0;
	endfunction

	task automatic send_word(logic op, logic [23:0] pix, bit typed = 0,
			blur_pix_t want = '0);
		blur_pix_t res;
		int kind;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		kind = blur_word(op, pix, res);
		if (kind >= 0)
			words_in++;
		if (typed)
			blur_q.push_back(want);
		else if (kind == 1)
			blur_q.push_back(res);
		if (kind == 1 && res.last)
			images_done++;
	endtask

	// stop offering and wait until every expected word has come out
	task automatic drain_wait();
		s_axis_tvalid <= 1'b0;
		while (blur_q.size() != 0)
			@(posedge clk);
	endtask

	// wait for the block to go quiet, then write one register
	task automatic write_reg(logic reg_sel, int value);
		s_axis_tvalid <= 1'b0;
		drain_wait();
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		set_geometry(reg_sel, value);
		settings_done++;
	endtask

	// output side: check accepted words, stall at random or hold off on request
	initial begin
		blur_pix_t exp_pix;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				words_out++;
				if (blur_q.size() == 0) begin
					$error("output word with nothing expected: %h last %b",
						m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					exp_pix = blur_q.pop_front();
					if (m_axis_tdata[7:0] !== exp_pix.blue) begin
						$error("blue_out: expected %0d, got %0d", exp_pix.blue,
							m_axis_tdata[7:0]);
						errors++;
					end
					if (m_axis_tdata[15:8] !== exp_pix.green) begin
						$error("green_out: expected %0d, got %0d", exp_pix.green,
							m_axis_tdata[15:8]);
						errors++;
					end
					if (m_axis_tdata[23:16] !== exp_pix.red) begin
						$error("red_out: expected %0d, got %0d", exp_pix.red,
							m_axis_tdata[23:16]);
						errors++;
					end
					if (m_axis_tlast !== exp_pix.last) begin
						$error("last_of_image: expected %0d, got %0d", exp_pix.last,
							m_axis_tlast);
						errors++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(99) >= rx_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout: no progress for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	dir_row_t dir_rows [27];

	initial begin
		dir_rows = '{
			'{1, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'h0, 0, '0},
			'{1, bb3_pkg::REG_HEIGHT, 0, bb3_pkg::OP_PIXEL, 24'h0, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h123456, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'h8000FF, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 1,
				'{8'hFF, 8'h00, 8'h80, 1'b1}},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'h000000, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'hFFFFFF, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 1,
				'{8'h00, 8'h00, 8'h00, 1'b1}},
			'{1, bb3_pkg::REG_WIDTH, 2, bb3_pkg::OP_PIXEL, 24'h0, 0, '0},
			'{1, bb3_pkg::REG_HEIGHT, 2, bb3_pkg::OP_PIXEL, 24'h0, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'hFFFFFF, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'hFFFFFF, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'hFFFFFF, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'hFFFFFF, 1,
				'{8'hFF, 8'hFF, 8'hFF, 1'b0}},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 1,
				'{8'hFF, 8'hFF, 8'hFF, 1'b0}},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 1,
				'{8'hFF, 8'hFF, 8'hFF, 1'b0}},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 1,
				'{8'hFF, 8'hFF, 8'hFF, 1'b1}},
			'{1, bb3_pkg::REG_WIDTH, 3, bb3_pkg::OP_PIXEL, 24'h0, 0, '0},
			'{1, bb3_pkg::REG_HEIGHT, 1, bb3_pkg::OP_PIXEL, 24'h0, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'h0A1400, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'h1E01FF, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'hFF0207, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_PIXEL, 24'h777777, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 0, '0},
			'{0, bb3_pkg::REG_WIDTH, 0, bb3_pkg::OP_FLUSH, 24'h0, 0, '0}
		};
	end

	initial begin
		int w_val, h_val, w, h, abort_at, n_img, phase;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = bb3_pkg::OP_PIXEL;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_mem[i] = '0;
			middle_mem[i] = '0;
		end
		img_width = 1024;
		img_height = 1024;
		restart_image();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].cfg_reg, dir_rows[i].cfg_val);
			else
				send_word(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].typed,
					dir_rows[i].want);
		end

		phase = 0;
		while (words_in < ITEM_TARGET) begin
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
				default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
			endcase
			abort_at = -1;
			if (phase == 0) begin
				// one full-width image, cut short once its second row is under way
				w_val = ($urandom_range(1) == 0) ? 2047 : 1024;
				h_val = $urandom_range(2, 3);
				abort_at = $urandom_range(1030, 1060);
			end else begin
				case ($urandom_range(99)) inside
					[0:2]: begin
						w_val = $urandom_range(1, 3);
						h_val = ($urandom_range(1) == 0) ? 8191 : 4096;
						abort_at = $urandom_range(20, 60);
					end
					[3:6]: begin
						w_val = $urandom_range(0, 1);
						h_val = $urandom_range(0, 1);
					end
					default: begin
						w_val = $urandom_range(1, 12);
						h_val = $urandom_range(1, 8);
					end
				endcase
			end
			if ($urandom_range(1) == 0) begin
				write_reg(bb3_pkg::REG_WIDTH, w_val);
				write_reg(bb3_pkg::REG_HEIGHT, h_val);
			end else begin
				write_reg(bb3_pkg::REG_HEIGHT, h_val);
				write_reg(bb3_pkg::REG_WIDTH, w_val);
			end
			w = img_width;
			h = img_height;
			n_img = (abort_at >= 0 || w * h > 64) ? 1 : $urandom_range(1, 3);
			for (int k = 0; k < n_img; k++) begin
				// hold off the output so the block fills up and stalls
				if (phase % 4 == 2 && k == 0)
					rx_hold_left = 300;
				for (int i = 0; i < w * h; i++) begin
					if (i == abort_at)
						break;
					if (phase % 4 == 3 && i == (w * h) / 2)
						drain_wait();
					if ($urandom_range(99) < 5)
						send_word(bb3_pkg::OP_FLUSH, 24'($urandom));
					send_word(bb3_pkg::OP_PIXEL, 24'($urandom));
				end
				if (abort_at >= 0)
					break;
				for (int i = 0; i <= w; i++)
					send_word(($urandom_range(99) < 70) ? bb3_pkg::OP_FLUSH
						: bb3_pkg::OP_PIXEL, 24'($urandom));
			end
			phase++;
		end

		s_axis_tvalid <= 1'b0;
		drain_wait();
		repeat (20) @(posedge clk);
		if (blur_q.size() != 0) begin
			$error("%0d expected words never arrived", blur_q.size());
			errors++;
		end
		$display("run covered %0d words in, %0d words out, %0d images, %0d register writes",
			words_in, words_out, images_done, settings_done);
		$display("sizes from 1x1 up to full width and full height, four idle patterns");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
